FILE: design/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Each macro expands to one labeled concurrent assertion on clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: design/htpb_pkg.sv
// Package for the Huffman tree path builder: command and result structs,
// stack control struct, mode and status codes. Depends on nothing.
`default_nettype none

package htpb_pkg;

  typedef struct packed {
    logic        mode;
    logic [31:0] freq;
    logic        last_word;
    logic [6:0]  word_sel;
  } htpb_cmd_t;

  typedef struct packed {
    logic       branch_bit;
    logic [5:0] inner_node;
    logic       last_step;
    logic       empty_path;
    logic [1:0] status;
  } htpb_result_t;

  typedef struct packed {
    logic push;
    logic pop;
  } htpb_stack_ctrl_t;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_TREE  = 2'd1;
  localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

endpackage

`default_nettype wire

FILE: design/htpb_path_stack.sv
// Last-in first-out buffer that holds the path entries of one query.
// Depends on htpb_pkg for the stack control struct.
`default_nettype none

module htpb_path_stack #(
  parameter int DW    = 8,
  parameter int DEPTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  htpb_pkg::htpb_stack_ctrl_t ctrl_i,
  input  logic [DW-1:0]             wdata_i,
  output logic [DW-1:0]             rdata_o,
  output logic                      empty_o
);
  import htpb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;
  logic [PW-1:0] ptr_q, ptr_d;

  always_comb begin
    ptr_d = ptr_q;
    if (ctrl_i.push) begin
      ptr_d = ptr_q + PW'(1);
    end else if (ctrl_i.pop) begin
      ptr_d = ptr_q - PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[ptr_q] <= wdata_i;
    end
    if (ctrl_i.pop) begin
      rdata_q <= mem[ptr_d];
    end
  end

  assign rdata_o = rdata_q;
  assign empty_o = (ptr_q == '0);

endmodule

`default_nettype wire

FILE: design/huffman_tree_path_builder_unit.sv
// Top level of the Huffman tree path builder: sequencer, node memories and merge unit.
// Depends on htpb_pkg and htpb_path_stack.
//
// Usage: a command is transferred when start is high and busy is low. A load
// command stores one frequency; words arrive in descending frequency order and
// the command with last_word set closes the load. Closing the load produces one
// status result and, when the count is valid, builds the tree first.
// A query command returns the path from the root down to the given word, one
// result per internal node, with last_step set on the leaf end; a query that
// has no path returns a single result with empty_path set.
// Each result is shown for one cycle with result_strobe_o; there is no back
// pressure, so every strobe is a completed transfer.
// A load without last_word leaves busy low. The build uses one shared
// compare-and-add unit over two weight memory reads; each merge picks its two
// children in turn, each with a read in S_BRD and a pick in S_BPICK. A query passes
// through S_QRD and S_QPUSH once per tree level on the way up through the parent
// memory, and S_QPOP and S_QOUT once per result on the way down through the path stack.
// busy stays high for the whole build or query.
// Reset clears the word count and the tree flag; the memories are not cleared,
// and every entry is written before its value is used.
`default_nettype none

module huffman_tree_path_builder_unit #(
  parameter int MAX_WORDS = 32,
  parameter int FREQ_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  htpb_pkg::htpb_cmd_t    cmd_i,
  output logic                   busy,
  output logic                   result_strobe_o,
  output htpb_pkg::htpb_result_t result_o
);
  import htpb_pkg::*;

  localparam int NB = $clog2(2 * MAX_WORDS);
  localparam int CW = $clog2(MAX_WORDS + 2);
  localparam int WW = FREQ_BITS + $clog2(MAX_WORDS);
  localparam int LB = (FREQ_BITS < 32) ? FREQ_BITS : 32;
  localparam int XW = (CW > 7) ? CW : 7;
  localparam int DW = NB + 1;
  localparam int NODES = 2 * MAX_WORDS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BRD   = 3'd1;
  localparam logic [2:0] S_BPICK = 3'd2;
  localparam logic [2:0] S_QRD   = 3'd3;
  localparam logic [2:0] S_QPUSH = 3'd4;
  localparam logic [2:0] S_QPOP  = 3'd5;
  localparam logic [2:0] S_QOUT  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          ready_q, ready_d;
  logic          closed_q, closed_d;
  logic [NB-1:0] l_q, l_d, r_q, r_d, i_q, i_d, node_q, node_d;
  logic          phase_q, phase_d;
  logic [WW-1:0] acc_q, acc_d;
  htpb_result_t  res_q, res_d;
  logic          strobe_q, strobe_d;

  logic [WW-1:0] wt_mem [NODES];
  logic [DW-1:0] pl_mem [NODES];
  logic [WW-1:0] wl_q, wr_q;
  logic [DW-1:0] pl_q;

  logic          accept;
  logic [CW-1:0] cnt_base, cnt_new;
  logic [NB-1:0] root;
  logic          take_leaf;
  logic [NB-1:0] pick;
  logic [WW-1:0] pw;
  logic          bad_index;

  logic          wt_we;
  logic [NB-1:0] wt_wa;
  logic [WW-1:0] wt_wd;
  logic          pl_we;
  logic [NB-1:0] pl_wa;
  logic [DW-1:0] pl_wd;

  htpb_stack_ctrl_t stk_ctrl;
  logic [DW-1:0]    stk_rdata;
  logic             stk_empty;

  assign accept    = start && (state_q == S_IDLE);
  assign cnt_base  = closed_q ? '0 : count_q;
  assign cnt_new   = (cnt_base < CW'(MAX_WORDS)) ? (cnt_base + CW'(1)) : CW'(MAX_WORDS + 1);
  assign root      = NB'({count_q, 1'b0}) - NB'(1);
  assign take_leaf = (l_q != '0) && ((r_q >= i_q) || (wl_q < wr_q));
  assign pick      = take_leaf ? l_q : r_q;
  assign pw        = take_leaf ? wl_q : wr_q;
  assign bad_index = (cmd_i.word_sel == 7'd0) ||
                     (XW'(cmd_i.word_sel) > XW'(count_q));

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ready_d  = ready_q;
    closed_d = closed_q;
    l_d      = l_q;
    r_d      = r_q;
    i_d      = i_q;
    node_d   = node_q;
    phase_d  = phase_q;
    acc_d    = acc_q;
    res_d    = res_q;
    strobe_d = 1'b0;
    wt_we    = 1'b0;
    wt_wa    = i_q;
    wt_wd    = acc_q + pw;
    pl_we    = 1'b0;
    pl_wa    = pick;
    pl_wd    = {phase_q, i_q};
    stk_ctrl = '0;

    case (state_q)
      S_IDLE: begin
        if (accept && (cmd_i.mode == MODE_LOAD)) begin
          count_d  = cnt_new;
          ready_d  = 1'b0;
          closed_d = 1'b0;
          if (cnt_base < CW'(MAX_WORDS)) begin
            wt_we = 1'b1;
            wt_wa = NB'(cnt_new);
            wt_wd = WW'(cmd_i.freq[LB-1:0]);
          end
          if (cmd_i.last_word) begin
            closed_d        = 1'b1;
            res_d           = '0;
            res_d.last_step = 1'b1;
            if (cnt_new > CW'(MAX_WORDS)) begin
              res_d.status = STATUS_TOO_MANY;
              strobe_d     = 1'b1;
            end else if (cnt_new < CW'(2)) begin
              res_d.status = STATUS_NO_TREE;
              strobe_d     = 1'b1;
            end else begin
              l_d     = NB'(cnt_new);
              r_d     = NB'(cnt_new) + NB'(1);
              i_d     = NB'(cnt_new) + NB'(1);
              phase_d = 1'b0;
              state_d = S_BRD;
            end
          end
        end else if (accept) begin
          res_d            = '0;
          res_d.last_step  = 1'b1;
          res_d.empty_path = 1'b1;
          if (!ready_q) begin
            res_d.status = STATUS_NO_TREE;
            strobe_d     = 1'b1;
          end else if (bad_index) begin
            res_d.status = STATUS_OK;
            strobe_d     = 1'b1;
          end else begin
            node_d  = NB'(cmd_i.word_sel);
            state_d = S_QRD;
          end
        end
      end
      S_BRD: begin
        state_d = S_BPICK;
      end
      S_BPICK: begin
        pl_we = 1'b1;
        if (take_leaf) begin
          l_d = l_q - NB'(1);
        end else begin
          r_d = r_q + NB'(1);
        end
        if (!phase_q) begin
          acc_d   = pw;
          phase_d = 1'b1;
          state_d = S_BRD;
        end else begin
          wt_we   = 1'b1;
          phase_d = 1'b0;
          if (i_q == root) begin
            ready_d      = 1'b1;
            res_d        = '0;
            res_d.last_step = 1'b1;
            res_d.status = STATUS_OK;
            strobe_d     = 1'b1;
            state_d      = S_IDLE;
          end else begin
            i_d     = i_q + NB'(1);
            state_d = S_BRD;
          end
        end
      end
      S_QRD: begin
        state_d = S_QPUSH;
      end
      S_QPUSH: begin
        stk_ctrl.push = 1'b1;
        if (pl_q[NB-1:0] == root) begin
          state_d = S_QPOP;
        end else begin
          node_d  = pl_q[NB-1:0];
          state_d = S_QRD;
        end
      end
      S_QPOP: begin
        stk_ctrl.pop = 1'b1;
        state_d      = S_QOUT;
      end
      S_QOUT: begin
        res_d            = '0;
        res_d.branch_bit = stk_rdata[NB];
        res_d.inner_node = 6'(stk_rdata[NB-1:0] - NB'(count_q) - NB'(1));
        res_d.last_step  = stk_empty;
        res_d.status     = STATUS_OK;
        strobe_d         = 1'b1;
        state_d          = stk_empty ? S_IDLE : S_QPOP;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ready_q  <= 1'b0;
      closed_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ready_q  <= ready_d;
      closed_q <= closed_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q     <= l_d;
    r_q     <= r_d;
    i_q     <= i_d;
    node_q  <= node_d;
    phase_q <= phase_d;
    acc_q   <= acc_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wt_we) begin
      wt_mem[wt_wa] <= wt_wd;
    end
    if (state_q == S_BRD) begin
      wl_q <= wt_mem[l_q];
      wr_q <= wt_mem[r_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pl_we) begin
      pl_mem[pl_wa] <= pl_wd;
    end
    if (state_q == S_QRD) begin
      pl_q <= pl_mem[node_q];
    end
  end

  htpb_path_stack #(
    .DW    (DW),
    .DEPTH (MAX_WORDS)
  ) u_path_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (stk_ctrl),
    .wdata_i (pl_q),
    .rdata_o (stk_rdata),
    .empty_o (stk_empty)
  );

  assign busy            = (state_q != S_IDLE);
  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

endmodule

`default_nettype wire

FILE: design/htpb_checker.sv
// Port-level checker for the Huffman tree path builder, bound to the top level.
// Depends on htpb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module htpb_checker (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   busy,
  input wire logic                   result_strobe_o,
  input wire htpb_pkg::htpb_result_t result_o
);
  import htpb_pkg::*;

  `ASSERT_IMPL(empty_is_last, result_strobe_o && result_o.empty_path, result_o.last_step)
  `ASSERT_IMPL(error_is_last, result_strobe_o && (result_o.status != STATUS_OK), result_o.last_step)
  `ASSERT_IMPL(mid_path_busy, result_strobe_o && !result_o.last_step, busy)
  `ASSERT_NEXT(path_spacing, result_strobe_o && !result_o.last_step, !result_strobe_o && busy)

endmodule

bind huffman_tree_path_builder_unit htpb_checker u_htpb_checker (.*);

`default_nettype wire
